// ----- src/ctsf_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsf_pkg - text stream filter shared definitions
// Character codes, configuration register indexes and types, the rendering
// function for the caret and M- notation, and default sizes.
// ----------------------------------------------------------------------------
package ctsf_pkg;

	localparam int NUMBER_DIGITS = 6;
	localparam int QUEUE_DEPTH   = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_SQUEEZE   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINT   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAB_CARET       = 3'd5;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_QUERY = 8'h3F;
	localparam logic [7:0] CHAR_UPPER_I = 8'h49;
	localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
	localparam logic [7:0] CHAR_CARET = 8'h5E;

	localparam logic [7:0] LAST_CTRL   = 8'd31;
	localparam logic [7:0] CHAR_DEL    = 8'd127;
	localparam logic [7:0] HIGH_FIRST  = 8'd128;
	localparam logic [7:0] HIGH_CTRL_LAST = 8'd159;
	localparam logic [7:0] HIGH_PRINT_FIRST = 8'd160;
	localparam logic [7:0] HIGH_PRINT_LAST  = 8'd254;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [7:0] META_OFFSET  = 8'd128;

	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic blank_squeeze;
		logic show_nonprint;
		logic show_ends;
		logic tab_caret;
	} cfg_t;

	// rendered byte: up to four characters, index of the last one
	typedef struct packed {
		logic [1:0]      last;
		logic [3:0][7:0] chars;
	} esc_t;

	function automatic esc_t render(input logic [7:0] c, input cfg_t cfg);
		esc_t r;
		r.last  = 2'd0;
		r.chars = '0;
		r.chars[0] = c;
		if (c == CHAR_TAB && cfg.tab_caret) begin
			r.last = 2'd1;
			r.chars[0] = CHAR_CARET;
			r.chars[1] = CHAR_UPPER_I;
		end else if (c == CHAR_NL && cfg.show_ends) begin
			r.last = 2'd1;
			r.chars[0] = CHAR_DOLLAR;
			r.chars[1] = CHAR_NL;
		end else if (cfg.show_nonprint) begin
			if (c <= LAST_CTRL && c != CHAR_TAB && c != CHAR_NL) begin
				r.last = 2'd1;
				r.chars[0] = CHAR_CARET;
				r.chars[1] = c + CARET_OFFSET;
			end else if (c == CHAR_DEL) begin
				r.last = 2'd1;
				r.chars[0] = CHAR_CARET;
				r.chars[1] = CHAR_QUERY;
			end else if (c >= HIGH_FIRST && c <= HIGH_CTRL_LAST) begin
				r.last = 2'd3;
				r.chars[0] = CHAR_UPPER_M;
				r.chars[1] = CHAR_DASH;
				r.chars[2] = CHAR_CARET;
				r.chars[3] = c - CARET_OFFSET;
			end else if (c >= HIGH_PRINT_FIRST && c <= HIGH_PRINT_LAST) begin
				r.last = 2'd2;
				r.chars[0] = CHAR_UPPER_M;
				r.chars[1] = CHAR_DASH;
				r.chars[2] = c - META_OFFSET;
			end else if (c > HIGH_PRINT_LAST) begin
				r.last = 2'd3;
				r.chars[0] = CHAR_UPPER_M;
				r.chars[1] = CHAR_DASH;
				r.chars[2] = CHAR_CARET;
				r.chars[3] = CHAR_QUERY;
			end
		end
		return r;
	endfunction

endpackage

// ----- src/ctsf_if.sv -----
// ----------------------------------------------------------------------------
// ctsf_if - stream channels of the text filter
// Input byte channel and output character channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface ctsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- src/ctsf_front.sv -----
// ----------------------------------------------------------------------------
// ctsf_front - byte intake and classification
// Holds configuration and line state, drops squeezed newlines, renders the
// line number and the byte's notation into one queue word.
// ----------------------------------------------------------------------------
module ctsf_front #(
	parameter int NUMBER_DIGITS = ctsf_pkg::NUMBER_DIGITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [ctsf_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ctsf_pkg::CFG_DATA_W-1:0]        cfg_data,
	ctsf_in_if.sink                                text,
	output logic                                   push_valid,
	input  logic                                   push_ready,
	output logic                                   num_en,
	output logic [NUMBER_DIGITS-1:0][7:0]          num_chars,
	output ctsf_pkg::esc_t                         esc
);

	localparam int CNT_W = 4 * NUMBER_DIGITS;

	ctsf_pkg::cfg_t   cfg_q;
	logic             prev_nl_q;
	logic             prev2_nl_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             nl;
	logic             squeeze;
	logic             take;

	assign nl         = (text.in_byte == ctsf_pkg::CHAR_NL);
	assign squeeze    = cfg_q.blank_squeeze && prev2_nl_q && prev_nl_q && nl;
	assign text.ready = push_ready;
	assign push_valid = text.valid && !squeeze;
	assign take       = push_valid && push_ready;
	assign num_en     = cfg_q.number_nonblank ? (!nl && prev_nl_q)
	                                          : (cfg_q.number_all && prev_nl_q);
	assign esc        = ctsf_pkg::render(text.in_byte, cfg_q);

	always_comb begin
		logic       lead;
		logic       full;
		logic       carry;
		logic [3:0] d;
		lead       = 1'b1;
		full       = 1'b1;
		carry      = 1'b1;
		count_next = count_q;
		num_chars  = '0;
		for (int p = 0; p < NUMBER_DIGITS; p++) begin
			d = count_q[4*(NUMBER_DIGITS-1-p) +: 4];
			if (d > 4'd9)
				d = 4'd9;
			lead = lead && (d == 4'd0) && (p != NUMBER_DIGITS - 1);
			num_chars[p] = lead ? ctsf_pkg::CHAR_SPACE : (ctsf_pkg::CHAR_ZERO + {4'd0, d});
		end
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = count_q[4*i +: 4];
			if (d != 4'd9)
				full = 1'b0;
			if (carry) begin
				if (d >= 4'd9) begin
					count_next[4*i +: 4] = 4'd0;
				end else begin
					count_next[4*i +: 4] = d + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (full)
			count_next = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= '0;
			prev_nl_q  <= 1'b1;
			prev2_nl_q <= 1'b0;
			count_q    <= CNT_W'(1);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ctsf_pkg::CFG_NUMBER_NONBLANK: cfg_q.number_nonblank <= cfg_data[0];
					ctsf_pkg::CFG_NUMBER_ALL:      cfg_q.number_all      <= cfg_data[0];
					ctsf_pkg::CFG_BLANK_SQUEEZE:   cfg_q.blank_squeeze   <= cfg_data[0];
					ctsf_pkg::CFG_SHOW_NONPRINT:   cfg_q.show_nonprint   <= cfg_data[0];
					ctsf_pkg::CFG_SHOW_ENDS:       cfg_q.show_ends       <= cfg_data[0];
					ctsf_pkg::CFG_TAB_CARET:       cfg_q.tab_caret       <= cfg_data[0];
					default: ;
				endcase
			end
			if (take) begin
				prev2_nl_q <= prev_nl_q;
				prev_nl_q  <= nl;
				if (num_en)
					count_q <= count_next;
			end
		end
	end

endmodule

// ----- src/ctsf_queue.sv -----
// ----------------------------------------------------------------------------
// ctsf_queue - short word queue between intake and emitter
// Register-based FIFO with occupancy count.
// ----------------------------------------------------------------------------
module ctsf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ctsf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             head_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- src/ctsf_back.sv -----
// ----------------------------------------------------------------------------
// ctsf_back - character emitter
// Steps through the number, tab and rendered characters of the head word,
// one character per cycle into a registered output unless the receiver stalls.
// ----------------------------------------------------------------------------
module ctsf_back #(
	parameter int NUMBER_DIGITS = ctsf_pkg::NUMBER_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  logic                          head_num_en,
	input  logic [NUMBER_DIGITS-1:0][7:0] head_num_chars,
	input  ctsf_pkg::esc_t                head_esc,
	output logic                          pop,
	ctsf_out_if.source                    chars
);

	localparam int POS_W = $clog2(NUMBER_DIGITS + 1);

	logic [7:0]       numtab [NUMBER_DIGITS+1];
	logic [POS_W-1:0] num_pos_q;
	logic [1:0]       esc_pos_q;
	logic             num_done_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;
	logic             adv;
	logic             step;
	logic             in_num;
	logic             last;
	logic [7:0]       cur;

	always_comb begin
		for (int p = 0; p < NUMBER_DIGITS; p++)
			numtab[p] = head_num_chars[p];
		numtab[NUMBER_DIGITS] = ctsf_pkg::CHAR_TAB;
	end

	assign adv    = !out_valid_q || chars.ready;
	assign step   = adv && head_valid;
	assign in_num = head_num_en && !num_done_q;
	assign last   = !in_num && (esc_pos_q == head_esc.last);
	assign cur    = in_num ? numtab[num_pos_q] : head_esc.chars[esc_pos_q];
	assign pop    = step && last;

	assign chars.valid     = out_valid_q;
	assign chars.out_char  = out_char_q;
	assign chars.last_char = out_last_q;

	always_ff @(posedge clk) begin
		if (step) begin
			out_char_q <= cur;
			out_last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			num_pos_q   <= '0;
			esc_pos_q   <= '0;
			num_done_q  <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= head_valid;
			if (step) begin
				if (in_num) begin
					if (num_pos_q == POS_W'(NUMBER_DIGITS)) begin
						num_pos_q  <= '0;
						num_done_q <= 1'b1;
					end else begin
						num_pos_q <= num_pos_q + POS_W'(1);
					end
				end else if (last) begin
					esc_pos_q  <= '0;
					num_done_q <= 1'b0;
				end else begin
					esc_pos_q <= esc_pos_q + 2'd1;
				end
			end
		end
	end

endmodule

// ----- src/cat_text_stream_filter.sv -----
// A taken byte is stored in the queue, then its first character is registered at
// the output. Throughput: one byte per cycle while each byte gives one character
// and the receiver is ready; a byte gives 1 to NUMBER_DIGITS+5 characters, set by
// the emitter's one-per-cycle pace. The intake queue (QUEUE_DEPTH words) absorbs
// number and notation bursts. Reset: configuration off, line counter at one, as
// if after a newline, queue and output empty.
// ----------------------------------------------------------------------------
// cat_text_stream_filter - line numbering and caret notation text filter
// Intake and classification, word queue, and character emitter.
// ----------------------------------------------------------------------------
module cat_text_stream_filter #(
	parameter int NUMBER_DIGITS = ctsf_pkg::NUMBER_DIGITS,
	parameter int QUEUE_DEPTH   = ctsf_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ctsf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ctsf_pkg::CFG_DATA_W-1:0]  cfg_data,
	ctsf_in_if.sink                          text,
	ctsf_out_if.source                       chars
);

	localparam int WORD_W = 1 + 8 * NUMBER_DIGITS + $bits(ctsf_pkg::esc_t);

	logic                          push_valid;
	logic                          push_ready;
	logic                          num_en;
	logic [NUMBER_DIGITS-1:0][7:0] num_chars;
	ctsf_pkg::esc_t                esc;
	logic                          head_valid;
	logic                          pop;
	logic [WORD_W-1:0]             head_word;
	logic                          head_num_en;
	logic [NUMBER_DIGITS-1:0][7:0] head_num_chars;
	ctsf_pkg::esc_t                head_esc;

	ctsf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text       (text),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.num_en     (num_en),
		.num_chars  (num_chars),
		.esc        (esc)
	);

	ctsf_queue #(.WIDTH(WORD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({num_en, num_chars, esc}),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_word)
	);

	assign {head_num_en, head_num_chars, head_esc} = head_word;

	ctsf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_num_en    (head_num_en),
		.head_num_chars (head_num_chars),
		.head_esc       (head_esc),
		.pop            (pop),
		.chars          (chars)
	);

endmodule

// ----- tb/tb_cat_text_stream_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cat_text_stream_filter - self-checking bench for the text stream filter
// Feeds text bytes through the input channel and checks every character
// against a behavioural model of numbering, blank-line squeezing and caret /
// M- notation. The bench runs directed corner bytes first, then random lines
// under a range of filter settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_cat_text_stream_filter;

	localparam int SETTLE_CYCLES = 16;
	localparam int PHASES        = 8;
	localparam int PHASE_BYTES   = 52;
	localparam int LINE_NO_W     = 4 * ctsf_pkg::NUMBER_DIGITS;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_word_t;

	class filter_scoreboard;
		ctsf_pkg::cfg_t               cfg;
		logic                         after_nl;
		logic                         after_two_nl;
		logic [LINE_NO_W-1:0]         line_no;
		logic [7:0]                   burst[$];
		out_word_t                    pending[$];
		int                           errors;
		int                           accepted;
		int                           checked;
		int                           squeezed;
		int                           numbered;

		function new();
			cfg          = '0;
			after_nl     = 1'b1;
			after_two_nl = 1'b0;
			line_no      = LINE_NO_W'(1);
		endfunction

		function void set_reg(logic [ctsf_pkg::CFG_INDEX_W-1:0] index, logic value);
			case (index)
				ctsf_pkg::CFG_NUMBER_NONBLANK: cfg.number_nonblank = value;
				ctsf_pkg::CFG_NUMBER_ALL:      cfg.number_all      = value;
				ctsf_pkg::CFG_BLANK_SQUEEZE:   cfg.blank_squeeze   = value;
				ctsf_pkg::CFG_SHOW_NONPRINT:   cfg.show_nonprint   = value;
				ctsf_pkg::CFG_SHOW_ENDS:       cfg.show_ends       = value;
				ctsf_pkg::CFG_TAB_CARET:       cfg.tab_caret       = value;
				default: ;
			endcase
		endfunction

		// BCD increment, holding at all nines
		function void bump_line_no();
			logic all_nines;
			all_nines = 1'b1;
			for (int i = 0; i < ctsf_pkg::NUMBER_DIGITS; i++)
				if (line_no[4*i +: 4] != 4'd9)
					all_nines = 1'b0;
			if (all_nines)
				return;
			for (int i = 0; i < ctsf_pkg::NUMBER_DIGITS; i++) begin
				if (line_no[4*i +: 4] == 4'd9) begin
					line_no[4*i +: 4] = 4'd0;
				end else begin
					line_no[4*i +: 4] = line_no[4*i +: 4] + 4'd1;
					break;
				end
			end
		endfunction

		function void render_byte(logic [7:0] b);
			if (b == ctsf_pkg::CHAR_TAB && cfg.tab_caret) begin
				burst.push_back(ctsf_pkg::CHAR_CARET);
				burst.push_back(ctsf_pkg::CHAR_UPPER_I);
			end else if (b == ctsf_pkg::CHAR_NL && cfg.show_ends) begin
				burst.push_back(ctsf_pkg::CHAR_DOLLAR);
				burst.push_back(ctsf_pkg::CHAR_NL);
			end else if (!cfg.show_nonprint) begin
				burst.push_back(b);
			end else if (b <= ctsf_pkg::LAST_CTRL && b != ctsf_pkg::CHAR_TAB
				&& b != ctsf_pkg::CHAR_NL) begin
				burst.push_back(ctsf_pkg::CHAR_CARET);
				burst.push_back(b + ctsf_pkg::CARET_OFFSET);
			end else if (b == ctsf_pkg::CHAR_DEL) begin
				burst.push_back(ctsf_pkg::CHAR_CARET);
				burst.push_back(ctsf_pkg::CHAR_QUERY);
			end else if (b >= ctsf_pkg::HIGH_FIRST) begin
				burst.push_back(ctsf_pkg::CHAR_UPPER_M);
				burst.push_back(ctsf_pkg::CHAR_DASH);
				if (b <= ctsf_pkg::HIGH_CTRL_LAST) begin
					burst.push_back(ctsf_pkg::CHAR_CARET);
					burst.push_back(b - ctsf_pkg::CARET_OFFSET);
				end else if (b <= ctsf_pkg::HIGH_PRINT_LAST) begin
					burst.push_back(b - ctsf_pkg::META_OFFSET);
				end else begin
					burst.push_back(ctsf_pkg::CHAR_CARET);
					burst.push_back(ctsf_pkg::CHAR_QUERY);
				end
			end else begin
				burst.push_back(b);
			end
		endfunction

		function void take_byte(logic [7:0] b);
			logic       is_nl;
			logic       lead;
			logic [3:0] digit;
			accepted++;
			is_nl = (b == ctsf_pkg::CHAR_NL);
			if (cfg.blank_squeeze && after_two_nl && after_nl && is_nl) begin
				squeezed++;
				return;
			end
			burst.delete();
			if (cfg.number_nonblank ? (!is_nl && after_nl) : (cfg.number_all && after_nl)) begin
				lead = 1'b1;
				for (int i = ctsf_pkg::NUMBER_DIGITS - 1; i >= 0; i--) begin
					digit = line_no[4*i +: 4];
					if (digit != 4'd0 || i == 0)
						lead = 1'b0;
					burst.push_back(lead ? ctsf_pkg::CHAR_SPACE
						: ctsf_pkg::CHAR_ZERO + {4'd0, digit});
				end
				burst.push_back(ctsf_pkg::CHAR_TAB);
				bump_line_no();
				numbered++;
			end
			render_byte(b);
			after_two_nl = after_nl;
			after_nl     = is_nl;
			foreach (burst[i])
				pending.push_back('{ch: burst[i], last: (i == burst.size() - 1)});
		endfunction

		function void check_char(logic [7:0] ch, logic last);
			out_word_t want;
			if (pending.size() == 0) begin
				$error("unexpected word: out_char 0x%02h last_char %0b", ch, last);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (ch !== want.ch) begin
				$error("out_char: expected 0x%02h, got 0x%02h", want.ch, ch);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_char: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [ctsf_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ctsf_pkg::CFG_DATA_W-1:0]  cfg_data;
	int                               sender_idle_pct;
	int                               receiver_stall_pct;
	int                               phase_sent;
	bit                               paused;

	ctsf_in_if  text_if ();
	ctsf_out_if chars_if ();

	filter_scoreboard score = new();

	cat_text_stream_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text      (text_if),
		.chars     (chars_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && chars_if.valid && chars_if.ready)
			score.check_char(chars_if.out_char, chars_if.last_char);
		chars_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			text_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		text_if.valid   <= 1'b1;
		text_if.in_byte <= b;
		do @(posedge clk); while (!text_if.ready);
		score.take_byte(b);
		phase_sent++;
	endtask

	task automatic drain();
		text_if.valid <= 1'b0;
		while (score.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input ctsf_pkg::cfg_t c);
		logic [ctsf_pkg::CFG_INDEX_W-1:0] regs [7];
		logic                             vals [7];
		regs = '{ctsf_pkg::CFG_NUMBER_NONBLANK, ctsf_pkg::CFG_NUMBER_ALL,
			ctsf_pkg::CFG_BLANK_SQUEEZE, ctsf_pkg::CFG_SHOW_NONPRINT,
			ctsf_pkg::CFG_SHOW_ENDS, ctsf_pkg::CFG_TAB_CARET,
			ctsf_pkg::CFG_INDEX_W'($urandom_range(ctsf_pkg::CFG_TAB_CARET + 1,
				2**ctsf_pkg::CFG_INDEX_W - 1))};
		vals = '{c.number_nonblank, c.number_all, c.blank_squeeze, c.show_nonprint,
			c.show_ends, c.tab_caret, 1'($urandom_range(1))};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			score.set_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_text_byte();
		case ($urandom_range(9))
			6:       return ctsf_pkg::CHAR_TAB;
			7:       return 8'($urandom_range(0, ctsf_pkg::LAST_CTRL));
			8, 9:    return 8'($urandom_range(ctsf_pkg::HIGH_FIRST, 255));
			default: return 8'($urandom_range(ctsf_pkg::CHAR_SPACE, ctsf_pkg::CHAR_DEL - 1));
		endcase
	endfunction

	// blank runs, ordinary lines, and the odd burst of raw noise
	task automatic send_line();
		int kind;
		kind = $urandom_range(99);
		if (kind < 15) begin
			repeat ($urandom_range(1, 4)) send_byte(ctsf_pkg::CHAR_NL);
		end else if (kind < 90) begin
			repeat ($urandom_range(0, 12)) send_byte(random_text_byte());
			send_byte(ctsf_pkg::CHAR_NL);
		end else begin
			repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		ctsf_pkg::cfg_t c;
		text_if.valid      = 1'b0;
		text_if.in_byte    = 8'h00;
		chars_if.ready     = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		arst_n             = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		phase_sent         = 0;
		paused             = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// filter off: 0xFF pair passes as data
		send_byte("A");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(ctsf_pkg::CHAR_NL);
		drain();

		write_config('1);
		send_byte(ctsf_pkg::CHAR_TAB);
		send_byte(8'h01);
		send_byte(ctsf_pkg::LAST_CTRL);
		send_byte(ctsf_pkg::CHAR_DEL);
		send_byte(ctsf_pkg::HIGH_FIRST);
		send_byte(ctsf_pkg::HIGH_CTRL_LAST);
		send_byte(ctsf_pkg::HIGH_PRINT_FIRST);
		send_byte(ctsf_pkg::HIGH_PRINT_LAST);
		send_byte(8'hFF);
		send_byte(ctsf_pkg::CHAR_SPACE);
		send_byte("~");
		repeat (4) send_byte(ctsf_pkg::CHAR_NL);
		send_byte("x");
		send_byte(ctsf_pkg::CHAR_NL);
		drain();

		c = '0;
		c.number_all    = 1'b1;
		c.blank_squeeze = 1'b1;
		write_config(c);
		repeat (3) send_byte(ctsf_pkg::CHAR_NL);
		send_byte("z");
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       c = '0;
				1:       c = '1;
				default: c = ctsf_pkg::cfg_t'($urandom_range(2**$bits(ctsf_pkg::cfg_t) - 1));
			endcase
			write_config(c);
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
				default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
			endcase
			phase_sent = 0;
			while (phase_sent < PHASE_BYTES) begin
				send_line();
				if (phase == 5 && !paused && phase_sent >= PHASE_BYTES / 2) begin
					paused = 1'b1;
					drain();
				end
			end
			drain();
		end

		$display("%0d bytes taken, %0d characters checked over %0d filter settings",
			score.accepted, score.checked, PHASES + 3);
		$display("%0d lines numbered, %0d blank lines squeezed",
			score.numbered, score.squeezed);
		if (score.errors == 0 && score.pending.size() == 0) begin
			$display("[cat_text_stream_filter] OK");
		end else begin
			if (score.pending.size() != 0)
				$error("%0d expected characters never arrived", score.pending.size());
			$display("[cat_text_stream_filter] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[cat_text_stream_filter] ERROR");
		$finish;
	end

endmodule
